// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BAS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// expression must never be true outside reset
`define BAS_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`endif

// ----- sv/bas_pkg.sv -----
// shared constants, types and compare function of the byte array sorter
// no dependencies
package bas_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  typedef struct packed {
    logic insert;  // take one byte into the cell chain
    logic shift;   // hand out the head cell and shift the chain down
  } cmd_t;

  typedef struct packed {
    logic last_one;  // one byte left in the chain
  } status_t;

  // true when a placed before b breaks the requested order
  function automatic logic out_of_order(input logic signed [7:0] a,
                                        input logic signed [7:0] b,
                                        input logic desc);
    return desc ? (a < b) : (a > b);
  endfunction

endpackage

// ----- sv/byte_array_sorter.sv -----
// byte array sorter: collects a set of signed bytes and returns it sorted.
// It takes one byte per cycle while collecting: every request is inserted in
// its sorted place in a chain of 64 byte cells in the cycle it is accepted.
// The request marked last ends the set; the sorter then drains the chain, one
// result per cycle while out_ready_i is high. No new byte is taken while a set
// drains. Bytes beyond 64 in one set are dropped and every result of that set
// has overflow_o set. The descending bit is written through the cfg channel,
// which is always ready; write it only while the sorter is idle.
// depends on bas_pkg, bas_ctrl, bas_datapath
module byte_array_sorter (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,
  // byte request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic signed [7:0] value_i,
  input  logic              last_i,
  // sorted result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [7:0] sorted_value_o,
  output logic              final_res_o,
  output logic              overflow_o
);

  bas_pkg::cmd_t    cmd;
  bas_pkg::status_t status;
  logic             descending_q;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      descending_q <= 1'b0;
    end else if (cfg_valid_i) begin
      descending_q <= cfg_data_i;
    end
  end

  // collect / drain sequencing
  bas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .cmd_o      (cmd)
  );

  // cell chain, count and drop flag
  bas_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .descending_i(descending_q),
    .value_i     (value_i),
    .status_o    (status),
    .head_o      (sorted_value_o),
    .dropped_o   (overflow_o)
  );

  // the head cell is the last result when one byte remains
  assign final_res_o = status.last_one;

endmodule

// ----- sv/bas_ctrl.sv -----
// controller of the byte array sorter: collect and drain phases
// depends on bas_pkg
module bas_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           last_i,
  input  logic           out_ready_i,
  input  bas_pkg::status_t status_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output bas_pkg::cmd_t  cmd_o
);

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_DRAIN   = 1'b1;

  logic state_q, state_d;

  assign in_ready_o   = (state_q == ST_COLLECT);
  assign out_valid_o  = (state_q == ST_DRAIN);
  assign cmd_o.insert = in_valid_i & in_ready_o;
  assign cmd_o.shift  = out_valid_o & out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: begin
        if (cmd_o.insert && last_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cmd_o.shift && status_i.last_one) state_d = ST_COLLECT;
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/bas_datapath.sv -----
// datapath of the byte array sorter: sorted insertion cell chain and count
// depends on bas_pkg
module bas_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bas_pkg::cmd_t            cmd_i,
  input  logic                     descending_i,
  input  logic signed [7:0]        value_i,
  output bas_pkg::status_t         status_o,
  output logic signed [7:0]        head_o,
  output logic                     dropped_o
);

  localparam int N = bas_pkg::MAX_ELEMENTS;

  logic signed [7:0]          cell_q [N];
  logic signed [7:0]          cell_d [N];
  logic [N-1:0]               after_new;  // new byte goes at or before this cell
  logic [bas_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       dropped_q, dropped_d;
  logic                       full;

  assign full              = (count_q == bas_pkg::CNT_W'(N));
  assign status_o.last_one = (count_q == bas_pkg::CNT_W'(1));
  assign head_o            = cell_q[0];
  assign dropped_o         = dropped_q;

  for (genvar g = 0; g < N; g++) begin : g_cell
    assign after_new[g] = (bas_pkg::CNT_W'(g) >= count_q) ||
                          bas_pkg::out_of_order(cell_q[g], value_i, descending_i);
    if (g == 0) begin : g_head
      always_comb begin
        cell_d[g] = cell_q[g];
        if (cmd_i.insert && !full) begin
          if (after_new[g]) cell_d[g] = value_i;
        end else if (cmd_i.shift) begin
          cell_d[g] = cell_q[g+1];
        end
      end
    end else if (g == N - 1) begin : g_tail
      always_comb begin
        cell_d[g] = cell_q[g];
        if (cmd_i.insert && !full && after_new[g]) begin
          cell_d[g] = after_new[g-1] ? cell_q[g-1] : value_i;
        end
      end
    end else begin : g_mid
      always_comb begin
        cell_d[g] = cell_q[g];
        if (cmd_i.insert && !full) begin
          if (after_new[g]) cell_d[g] = after_new[g-1] ? cell_q[g-1] : value_i;
        end else if (cmd_i.shift) begin
          cell_d[g] = cell_q[g+1];
        end
      end
    end
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (cmd_i.insert) begin
      if (full) dropped_d = 1'b1;
      else      count_d   = count_q + bas_pkg::CNT_W'(1);
    end else if (cmd_i.shift) begin
      count_d = count_q - bas_pkg::CNT_W'(1);
      if (status_o.last_one) dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) cell_q[i] <= cell_d[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

endmodule

// ----- sv/byte_array_sorter_checker.sv -----
// port-level checks of byte_array_sorter, attached by bind
// depends on assert_macros.svh and byte_array_sorter
`include "assert_macros.svh"
module byte_array_sorter_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              last_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic signed [7:0] sorted_value_o,
  input logic              final_res_o,
  input logic              overflow_o
);

  // no request taken while a set drains
  `BAS_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o, "ready while draining")

  // a last request starts the drain in the next cycle
  `BAS_ASSERT(a_drain_starts, clk_i, rst_ni,
              in_valid_i && in_ready_o && last_i |=> out_valid_o, "no drain after last")

  // the final result ends the drain
  `BAS_ASSERT(a_drain_ends, clk_i, rst_ni,
              out_valid_o && out_ready_i && final_res_o |=> !out_valid_o, "drain past final")

  // overflow holds through the drain of a set
  `BAS_ASSERT(a_overflow_steady, clk_i, rst_ni,
              out_valid_o && !final_res_o |=> overflow_o == $past(overflow_o),
              "overflow changed inside a set")

  // stalled result holds
  `BAS_ASSERT(a_result_holds, clk_i, rst_ni,
              out_valid_o && !out_ready_i |=> out_valid_o && $stable(sorted_value_o),
              "stalled result changed")

endmodule

bind byte_array_sorter byte_array_sorter_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .last_i        (last_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .sorted_value_o(sorted_value_o),
  .final_res_o   (final_res_o),
  .overflow_o    (overflow_o)
);
